/* sv/bzs_pkg.sv */
package bzs_pkg;

  localparam int TF = 30;                 // fractional bits of t
  localparam int SH = TF - 15;            // Q1.15 to internal scale
  localparam int VW = TF + 10;            // signed working width
  localparam int MW = VW - 1;             // magnitude width
  localparam int LO_W = 20;               // low slice of the split multiply
  localparam int HI_W = MW - LO_W;
  localparam int MAX_ITERATIONS = 16;
  localparam int IT_W = $clog2(MAX_ITERATIONS + 1);

  localparam int NUM_REGS = 7;
  localparam logic [2:0] REG_START = 3'd0;
  localparam logic [2:0] REG_END   = 3'd1;
  localparam logic [2:0] REG_AINST = 3'd2;
  localparam logic [2:0] REG_AVAL  = 3'd3;
  localparam logic [2:0] REG_BINST = 3'd4;
  localparam logic [2:0] REG_BVAL  = 3'd5;
  localparam logic [2:0] REG_TOL   = 3'd6;

  // one step of the restoring divider as it travels down the chain
  typedef struct packed {
    logic          vld;
    logic          ovf;
    logic [VW-1:0] r;
    logic [MW-1:0] m;
    logic [TF:0]   q;
  } div_cell_t;

endpackage

/* sv/cubic_bezier_shaper.sv */
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid/in_tready    tdata: instant; tlast: in_last
// out_     master     out_tvalid/out_tready  tdata: value; tuser: not_converged;
//                                            tlast: out_last
// cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One item at a time. Each Newton iteration issues five multiplies on one
// split multiplier and, unless the derivative is flat, one pass down the
// divider chain.
// Reset (rst_n low, synchronous) restores the register defaults and idles.
// A result held in the output register does not block the next transfer in.
module cubic_bezier_shaper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] instant
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] value
  output logic        out_tuser,   // [0] not_converged
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bzs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_MUL, S_DIV, S_ROUND} state_t;
  typedef enum logic [2:0] {ST_F1, ST_F2, ST_F3, ST_D1, ST_D2,
                            ST_Y1, ST_Y2, ST_Y3} step_t;

  localparam logic [TF:0] ONE_T = (TF+1)'(1) << TF;

  // configuration registers
  logic signed [15:0] start_r, end_r, aval_r, bval_r;
  logic        [15:0] ainst_r, binst_r;
  logic        [14:0] tol_r;

  state_t state_r;
  step_t  step_r;

  logic [15:0] inst_r;
  logic        last_r;
  logic        nc_r;
  logic [TF:0] x_r, t_r;
  logic [IT_W-1:0] it_r;
  logic signed [VW-1:0] cx1_r, cx2_r, cx3_r, cy0_r, cy1_r, cy2_r, cy3_r, y_r;
  logic f_neg_r, d_neg_r;
  logic [MW-1:0] f_mag_r;

  logic                 mul_start_r;
  logic signed [VW-1:0] mul_v_r;
  logic                 mul_done;
  logic signed [VW-1:0] mul_res;
  logic                 div_start_r;
  logic [MW-1:0]        div_n_r, div_m_r;
  logic                 div_done;
  logic [TF+1:0]        div_q;

  logic        out_tvalid_r, out_nc_r, out_last_r;
  logic [15:0] out_value_r;

  function automatic logic signed [VW-1:0] scale_q15(input logic signed [19:0] v);
    scale_q15 = VW'(v) <<< SH;
  endfunction

  function automatic logic [16:0] clamp_inst(input logic [15:0] v);
    clamp_inst = (v > 16'd32768) ? 17'd32768 : {1'b0, v};
  endfunction

  // coefficients in Q15 integer units
  logic signed [19:0] a_i, b_i, s_i, e_i, av_i, bv_i;
  logic signed [19:0] cx1_i, cx2_i, cx3_i, cy1_i, cy2_i, cy3_i;
  logic [16:0]        x_q;

  assign a_i  = 20'(clamp_inst(ainst_r));
  assign b_i  = 20'(clamp_inst(binst_r));
  assign s_i  = 20'(start_r);
  assign e_i  = 20'(end_r);
  assign av_i = 20'(aval_r);
  assign bv_i = 20'(bval_r);
  assign cx1_i = 20'sd3 * a_i;
  assign cx2_i = 20'sd3 * b_i - 20'sd6 * a_i;
  assign cx3_i = 20'sd32768 + 20'sd3 * a_i - 20'sd3 * b_i;
  assign cy1_i = 20'sd3 * av_i - 20'sd3 * s_i;
  assign cy2_i = 20'sd3 * s_i - 20'sd6 * av_i + 20'sd3 * bv_i;
  assign cy3_i = e_i - s_i + 20'sd3 * av_i - 20'sd3 * bv_i;
  assign x_q   = clamp_inst(inst_r);

  // Newton update
  logic signed [TF+2:0] t_sum;
  logic [TF:0]          t_clamp;
  logic                 conv;
  logic signed [VW-1:0] f_val, d_val;

  assign t_sum = (f_neg_r ^ d_neg_r) ? $signed({2'b00, t_r}) + $signed({1'b0, div_q})
                                     : $signed({2'b00, t_r}) - $signed({1'b0, div_q});
  assign t_clamp = t_sum[TF+2] ? '0 :
                   (t_sum > $signed({2'b00, ONE_T})) ? ONE_T : t_sum[TF:0];
  assign conv  = div_q <= ((TF+2)'(tol_r) << SH);
  assign f_val = mul_res - $signed({{(VW-TF-1){1'b0}}, x_r});
  assign d_val = mul_res + cx1_r;

  // rounding: add half, floor shift, saturate
  logic signed [VW-1:0] y_sh;
  assign y_sh = (y_r + (VW'(1) <<< (SH - 1))) >>> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      ainst_r <= 16'd8192;
      aval_r  <= '0;
      binst_r <= 16'd24576;
      bval_r  <= '0;
      tol_r   <= 15'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START: start_r <= cfg_data;
        REG_END:   end_r   <= cfg_data;
        REG_AINST: ainst_r <= cfg_data;
        REG_AVAL:  aval_r  <= cfg_data;
        REG_BINST: binst_r <= cfg_data;
        REG_BVAL:  bval_r  <= cfg_data;
        REG_TOL:   tol_r   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= ST_F1;
      mul_start_r  <= 1'b0;
      div_start_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      // drop valid after the transfer unless a new result replaces it
      if (out_tvalid_r && out_tready && state_r != S_ROUND) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            inst_r  <= in_tdata;
            last_r  <= in_tlast;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          cx1_r <= scale_q15(cx1_i);
          cx2_r <= scale_q15(cx2_i);
          cx3_r <= scale_q15(cx3_i);
          cy0_r <= scale_q15(s_i);
          cy1_r <= scale_q15(cy1_i);
          cy2_r <= scale_q15(cy2_i);
          cy3_r <= scale_q15(cy3_i);
          x_r   <= (TF+1)'(x_q) << SH;
          t_r   <= (TF+1)'(x_q) << SH;
          it_r  <= '0;
          nc_r        <= 1'b1;
          mul_v_r     <= scale_q15(cx3_i);
          mul_start_r <= 1'b1;
          step_r      <= ST_F1;
          state_r     <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            mul_start_r <= 1'b1;
            unique case (step_r)
              ST_F1: begin
                mul_v_r <= mul_res + cx2_r;
                step_r  <= ST_F2;
              end
              ST_F2: begin
                mul_v_r <= mul_res + cx1_r;
                step_r  <= ST_F3;
              end
              ST_F3: begin
                f_neg_r <= f_val[VW-1];
                f_mag_r <= f_val[VW-1] ? MW'(-f_val) : MW'(f_val);
                mul_v_r <= cx3_r + (cx3_r <<< 1);
                step_r  <= ST_D1;
              end
              ST_D1: begin
                mul_v_r <= mul_res + (cx2_r <<< 1);
                step_r  <= ST_D2;
              end
              ST_D2: begin
                if (d_val == '0) begin
                  // flat derivative: keep t, flag it, go evaluate y
                  mul_v_r <= cy3_r;
                  step_r  <= ST_Y1;
                end else begin
                  mul_start_r <= 1'b0;
                  d_neg_r     <= d_val[VW-1];
                  div_n_r     <= f_mag_r;
                  div_m_r     <= d_val[VW-1] ? MW'(-d_val) : MW'(d_val);
                  div_start_r <= 1'b1;
                  state_r     <= S_DIV;
                end
              end
              ST_Y1: begin
                mul_v_r <= mul_res + cy2_r;
                step_r  <= ST_Y2;
              end
              ST_Y2: begin
                mul_v_r <= mul_res + cy1_r;
                step_r  <= ST_Y3;
              end
              default: begin
                mul_start_r <= 1'b0;
                y_r         <= mul_res + cy0_r;
                state_r     <= S_ROUND;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            t_r  <= t_clamp;
            it_r <= it_r + IT_W'(1);
            mul_start_r <= 1'b1;
            state_r     <= S_MUL;
            if (conv || (it_r == IT_W'(MAX_ITERATIONS - 1))) begin
              nc_r     <= !conv;
              mul_v_r  <= cy3_r;
              step_r   <= ST_Y1;
            end else begin
              mul_v_r  <= cx3_r;
              step_r   <= ST_F1;
            end
          end
        end
        default: begin
          // hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_last_r   <= last_r;
            out_nc_r     <= nc_r;
            if (y_sh > VW'(32767)) begin
              out_value_r <= 16'h7FFF;
            end else if (y_sh < -VW'(32768)) begin
              out_value_r <= 16'h8000;
            end else begin
              out_value_r <= y_sh[15:0];
            end
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  bzs_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start_r),
    .v    (mul_v_r),
    .t    (t_r),
    .done (mul_done),
    .res  (mul_res)
  );

  bzs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start_r),
    .n    (div_n_r),
    .m    (div_m_r),
    .done (div_done),
    .q    (div_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_nc_r;
  assign out_tlast  = out_last_r;

endmodule

/* sv/bzs_mul.sv */
module bzs_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [bzs_pkg::VW-1:0] v,
  input  logic        [bzs_pkg::TF:0]   t,
  output logic                         done,
  output logic signed [bzs_pkg::VW-1:0] res
);
  import bzs_pkg::*;

  logic [1:0]             ph_r;
  logic                   neg_r;
  logic [MW-1:0]          mag_r;
  logic [TF:0]            t_r;
  logic [LO_W+TF:0]       lo_r;
  logic [HI_W+TF:0]       hi_r;
  logic                   done_r;
  logic signed [VW-1:0]   res_r;
  logic [MW+TF:0]         sum;
  logic [MW-1:0]          shr;

  // recombine partial products and drop the fraction
  assign sum = ((MW+TF+1)'(hi_r) << LO_W) + (MW+TF+1)'(lo_r);
  assign shr = sum[MW+TF-1:TF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        2'd0: begin
          if (start) begin
            neg_r <= v[VW-1];
            mag_r <= v[VW-1] ? MW'(-v) : MW'(v);
            t_r   <= t;
            ph_r  <= 2'd1;
          end
        end
        2'd1: begin
          lo_r <= mag_r[LO_W-1:0] * t_r;
          ph_r <= 2'd2;
        end
        2'd2: begin
          hi_r <= mag_r[MW-1:LO_W] * t_r;
          ph_r <= 2'd3;
        end
        default: begin
          res_r  <= neg_r ? -$signed({1'b0, shr}) : $signed({1'b0, shr});
          done_r <= 1'b1;
          ph_r   <= 2'd0;
        end
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* sv/bzs_div_cell.sv */
module bzs_div_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bzs_pkg::div_cell_t    din,
  output bzs_pkg::div_cell_t    dout
);
  import bzs_pkg::*;

  div_cell_t     out_r;
  logic [VW-1:0] rs;
  logic          ge;

  assign rs = {din.r[VW-2:0], 1'b0};
  assign ge = rs >= {1'b0, din.m};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else begin
      out_r.vld <= din.vld;
    end
    out_r.ovf <= din.ovf;
    out_r.m   <= din.m;
    out_r.r   <= ge ? rs - {1'b0, din.m} : rs;
    out_r.q   <= {din.q[TF-1:0], ge};
  end

  assign dout = out_r;

endmodule

/* sv/bzs_div.sv */
module bzs_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [bzs_pkg::MW-1:0] n,
  input  logic [bzs_pkg::MW-1:0] m,
  output logic                   done,
  output logic [bzs_pkg::TF+1:0] q
);
  import bzs_pkg::*;

  div_cell_t chain [TF+1];
  div_cell_t head_r;
  logic      q0;

  assign q0 = n >= m;

  // integer quotient bit; two or more saturates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else begin
      head_r.vld <= start;
    end
    head_r.ovf <= {1'b0, n} >= {m, 1'b0};
    head_r.m   <= m;
    head_r.r   <= q0 ? VW'(n - m) : VW'(n);
    head_r.q   <= (TF+1)'(q0);
  end

  assign chain[0] = head_r;

  for (genvar i = 0; i < TF; i++) begin : g_cell
    bzs_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  assign done = chain[TF].vld;
  assign q    = chain[TF].ovf ? ((TF+2)'(1) << (TF + 1)) : {1'b0, chain[TF].q};

endmodule
